// ===== design/fec_pkg.sv =====
`default_nettype none

package fec_pkg;

    localparam int OP_W        = 3;
    localparam int TICK_W      = 16;
    localparam int PHASE_W     = 3;
    localparam int BLEND_W     = 17;
    localparam int LEFT_W      = 18;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int HAS_OUT_W   = 14;

    // weight counts as audible when weight * 10000 > one
    localparam logic [HAS_OUT_W-1:0] HAS_OUT_SCALE = 14'd10000;

    localparam logic [CFG_IDX_W-1:0] CFG_FADE_IN     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_OUT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_HLD = 2'd2;

    typedef enum logic [OP_W-1:0] {
        OP_TICK    = 3'd0,
        OP_TRIGGER = 3'd1,
        OP_STOP    = 3'd2,
        OP_PAUSE   = 3'd3,
        OP_RESUME  = 3'd4
    } t_op;

    typedef enum logic [PHASE_W-1:0] {
        PH_INACTIVE = 3'd0,
        PH_FADE_IN  = 3'd1,
        PH_HOLD     = 3'd2,
        PH_FADE_OUT = 3'd3,
        PH_PAUSED   = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_PREP,
        S_DIV,
        S_MUL1,
        S_MUL2,
        S_DONE
    } t_state;

    typedef struct packed {
        logic capture;
        logic exec;
        logic prep;
        logic div_step;
        logic mul1;
        logic mul2;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic tick_go;
        logic direct;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== design/fec_if.sv =====
`default_nettype none

interface fec_item_if import fec_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [OP_W-1:0]      op;
    logic [TICK_W-1:0]    elapsed_ticks;
    logic [TICK_W-1:0]    hold_override;
    logic                 immediate;

    modport source (output valid, output op, output elapsed_ticks, output hold_override,
                    output immediate, input ready);
    modport sink   (input valid, input op, input elapsed_ticks, input hold_override,
                    input immediate, output ready);
endinterface

interface fec_result_if import fec_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [PHASE_W-1:0]   phase;
    logic [BLEND_W-1:0]   blend_weight;
    logic [LEFT_W-1:0]    time_left;
    logic                 has_output;

    modport source (output valid, output phase, output blend_weight, output time_left,
                    output has_output, input ready);
    modport sink   (input valid, input phase, input blend_weight, input time_left,
                    input has_output, output ready);
endinterface

`default_nettype wire

// ===== design/fec_datapath.sv =====
`default_nettype none

module fec_datapath import fec_pkg::*; #(
    parameter int TIME_BITS        = 16,
    parameter int WEIGHT_FRAC_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic [OP_W-1:0]        i_op,
    input  logic [TICK_W-1:0]      i_elapsed_ticks,
    input  logic [TICK_W-1:0]      i_hold_override,
    input  logic                   i_immediate,
    input  t_dp_cmd                i_cmd,
    output t_dp_stat               o_stat,
    input  logic                   i_out_ready,
    output logic                   o_out_valid,
    output logic [PHASE_W-1:0]     o_phase,
    output logic [BLEND_W-1:0]     o_blend_weight,
    output logic [LEFT_W-1:0]      o_time_left,
    output logic                   o_has_output
);

    localparam int WB = WEIGHT_FRAC_BITS + 1;
    localparam int CW = ((TIME_BITS > TICK_W) ? TIME_BITS : TICK_W) + 1;
    localparam int RW = TICK_W + 1;
    localparam int PW = WB + HAS_OUT_W;
    localparam logic [WB-1:0] WONE = {1'b1, {WEIGHT_FRAC_BITS{1'b0}}};
    localparam logic [CW-1:0] TMAX = CW'({TIME_BITS{1'b1}});

    // configuration
    logic [TICK_W-1:0] r_fade_in, r_fade_out, r_dflt_hold;

    // latched word
    t_op               r_op;
    logic [TICK_W-1:0] r_elapsed, r_hold_ovr;
    logic              r_imm;

    // envelope state
    t_phase                r_phase, r_before;
    logic [TIME_BITS-1:0]  r_ptime;
    logic [TICK_W-1:0]     r_hold;
    logic [WB-1:0]         r_weight;

    // weight unit
    logic [RW-1:0]     r_rem;
    logic [TICK_W-1:0] r_den;
    logic [WB-1:0]     r_quo;
    logic [WB-1:0]     r_sq;

    // result register
    logic              r_out_valid;
    t_phase            r_out_phase;
    logic [BLEND_W-1:0] r_out_weight;
    logic [LEFT_W-1:0] r_out_left;
    logic              r_out_has;

    t_phase                n_phase, n_before;
    logic [TIME_BITS-1:0]  n_ptime;
    logic [TICK_W-1:0]     n_hold;

    logic [CW-1:0]         pt_ext, fi_ext, fo_ext, hl_ext, tick_sum, pt_sat;
    logic [TIME_BITS-1:0]  pt_new;
    logic                  active;
    logic [TICK_W-1:0]     pt16;

    logic                  direct;
    logic [WB-1:0]         direct_val;
    logic [TICK_W-1:0]     num_sel, den_sel;

    logic                  rem_ge;
    logic [RW-1:0]         rem_diff, rem_next;
    logic [2*WB-1:0]       sq_prod;
    logic [WB:0]           fac;
    logic [2*WB:0]         w_prod;

    logic [TICK_W-1:0]     rem_in, rem_hold, rem_out;
    logic [LEFT_W-1:0]     left;
    logic [PW-1:0]         has_prod;
    logic                  has_out;

    assign pt_ext   = CW'(r_ptime);
    assign fi_ext   = CW'(r_fade_in);
    assign fo_ext   = CW'(r_fade_out);
    assign hl_ext   = CW'(r_hold);
    assign pt16     = TICK_W'(r_ptime);
    assign tick_sum = pt_ext + CW'(r_elapsed);
    assign pt_sat   = (tick_sum > TMAX) ? TMAX : tick_sum;
    assign pt_new   = pt_sat[TIME_BITS-1:0];
    assign active   = (r_phase != PH_INACTIVE) && (r_phase != PH_PAUSED);

    // op execution
    always_comb begin
        n_phase  = r_phase;
        n_before = r_before;
        n_ptime  = r_ptime;
        n_hold   = r_hold;
        unique case (r_op)
            OP_TICK: begin
                if (active) begin
                    n_ptime = pt_new;
                    case (r_phase)
                        PH_FADE_IN: begin
                            if (r_fade_in == '0 || CW'(pt_new) >= fi_ext) begin
                                n_phase = PH_HOLD;
                                n_ptime = '0;
                            end
                        end
                        PH_HOLD: begin
                            if (r_hold != '0 && CW'(pt_new) >= hl_ext) begin
                                n_phase = PH_FADE_OUT;
                                n_ptime = '0;
                            end
                        end
                        PH_FADE_OUT: begin
                            if (r_fade_out == '0 || CW'(pt_new) >= fo_ext) begin
                                n_phase = PH_INACTIVE;
                                n_ptime = '0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            OP_TRIGGER: begin
                n_hold = (r_hold_ovr != '0) ? r_hold_ovr : r_dflt_hold;
                if (r_phase != PH_FADE_IN) begin
                    n_phase = PH_FADE_IN;
                    n_ptime = '0;
                end
            end
            OP_STOP: begin
                if (r_phase != PH_INACTIVE) begin
                    if (r_imm) begin
                        n_phase = PH_INACTIVE;
                        n_ptime = '0;
                    end else if (r_phase != PH_FADE_OUT) begin
                        n_phase = PH_FADE_OUT;
                        n_ptime = '0;
                    end
                end
            end
            OP_PAUSE: begin
                if (active) begin
                    n_before = r_phase;
                    n_phase  = PH_PAUSED;
                end
            end
            OP_RESUME: begin
                if (r_phase == PH_PAUSED) begin
                    n_phase = r_before;
                end
            end
            default: ;
        endcase
    end

    // weight setup, from the state after the tick
    always_comb begin
        direct     = 1'b1;
        direct_val = '0;
        num_sel    = '0;
        den_sel    = r_fade_in;
        case (r_phase)
            PH_FADE_IN: begin
                if (r_fade_in == '0 || pt_ext >= fi_ext) begin
                    direct_val = WONE;
                end else begin
                    direct  = 1'b0;
                    num_sel = pt16;
                end
            end
            PH_HOLD: direct_val = WONE;
            PH_FADE_OUT: begin
                den_sel = r_fade_out;
                if (!(r_fade_out == '0 || pt_ext >= fo_ext)) begin
                    direct  = 1'b0;
                    num_sel = r_fade_out - pt16;
                end
            end
            PH_PAUSED: direct_val = r_weight;
            default: ;
        endcase
    end

    // restoring division num * ONE / den, one quotient bit per cycle
    assign rem_ge   = r_rem >= RW'(r_den);
    assign rem_diff = r_rem - RW'(r_den);
    assign rem_next = (rem_ge ? rem_diff : r_rem) << 1;

    assign sq_prod = (2*WB)'(r_quo) * (2*WB)'(r_quo);
    assign fac     = {WONE, 1'b0} + (WB+1)'(WONE) - {r_quo, 1'b0};
    assign w_prod  = (2*WB+1)'(r_sq) * (2*WB+1)'(fac);

    // result fields
    assign rem_in   = (fi_ext > pt_ext) ? (r_fade_in - pt16) : '0;
    assign rem_hold = (hl_ext > pt_ext) ? (r_hold - pt16) : '0;
    assign rem_out  = (fo_ext > pt_ext) ? (r_fade_out - pt16) : '0;

    always_comb begin
        case (r_phase)
            PH_FADE_IN:  left = LEFT_W'(rem_in) + LEFT_W'(r_hold) + LEFT_W'(r_fade_out);
            PH_HOLD:     left = LEFT_W'(rem_hold) + LEFT_W'(r_fade_out);
            PH_FADE_OUT: left = LEFT_W'(rem_out);
            default:     left = '0;
        endcase
    end

    assign has_prod = PW'(r_weight) * PW'(HAS_OUT_SCALE);
    assign has_out  = (r_phase != PH_INACTIVE) && (has_prod > PW'(WONE));

    assign o_stat.tick_go  = (r_op == OP_TICK) && active;
    assign o_stat.direct   = direct;
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fade_in   <= '0;
            r_fade_out  <= '0;
            r_dflt_hold <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FADE_IN:     r_fade_in   <= i_cfg_data;
                CFG_FADE_OUT:    r_fade_out  <= i_cfg_data;
                CFG_DEFAULT_HLD: r_dflt_hold <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op       <= t_op'(i_op);
            r_elapsed  <= i_elapsed_ticks;
            r_hold_ovr <= i_hold_override;
            r_imm      <= i_immediate;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_INACTIVE;
            r_before <= PH_INACTIVE;
            r_ptime  <= '0;
            r_hold   <= '0;
            r_weight <= '0;
        end else begin
            if (i_cmd.exec) begin
                r_phase  <= n_phase;
                r_before <= n_before;
                r_ptime  <= n_ptime;
                r_hold   <= n_hold;
            end
            if (i_cmd.prep && direct) begin
                r_weight <= direct_val;
            end else if (i_cmd.mul2) begin
                r_weight <= w_prod[WEIGHT_FRAC_BITS +: WB];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_rem <= RW'(num_sel);
            r_den <= den_sel;
            r_quo <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= rem_next;
            r_quo <= {r_quo[WB-2:0], rem_ge};
        end
        if (i_cmd.mul1) begin
            r_sq <= sq_prod[WEIGHT_FRAC_BITS +: WB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_phase  <= r_phase;
            r_out_weight <= BLEND_W'(r_weight);
            r_out_left   <= left;
            r_out_has    <= has_out;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_phase        = r_out_phase;
    assign o_blend_weight = r_out_weight;
    assign o_time_left    = r_out_left;
    assign o_has_output   = r_out_has;

endmodule

`default_nettype wire

// ===== design/fec_ctrl.sv =====
`default_nettype none

module fec_ctrl import fec_pkg::*; #(
    parameter int WEIGHT_FRAC_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_dp_stat  i_stat,
    output t_dp_cmd   o_cmd
);

    localparam int WB   = WEIGHT_FRAC_BITS + 1;
    localparam int CNTW = $clog2(WB);

    t_state          r_state, n_state;
    logic [CNTW-1:0] r_cnt;
    logic            div_last;

    assign div_last = (r_cnt == CNTW'(WB - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_PREP) begin
            r_cnt <= '0;
        end else if (r_state == S_DIV) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_stat.tick_go ? S_PREP : S_DONE;
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = i_stat.direct ? S_DONE : S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (div_last) begin
                    n_state = S_MUL1;
                end
            end
            S_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                // wait for the result register to drain
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ===== design/fade_envelope_controller_core.sv =====
`default_nettype none

// channel    dir   handshake        payload
// i_item     in    valid / ready    op, elapsed_ticks, hold_override, immediate
// o_result   out   valid / ready    phase, blend_weight, time_left, has_output
// i_cfg_*    in    write enable     idx 0 fade_in, 1 fade_out, 2 default_hold
//
// One word at a time. A tick that leaves the envelope fading runs the restoring
// divider, which yields one quotient bit per cycle, then two multiply stages form the
// smoothstep. Other ticks on a live envelope set the weight directly in S_PREP; all
// other words go from S_EXEC straight to S_DONE.
// Synchronous active-low reset: envelope inactive, configuration and state zero. A stalled
// result holds in the output register; the next word is taken, its result waits in S_DONE.
module fade_envelope_controller_core import fec_pkg::*; #(
    parameter int TIME_BITS        = 16,
    parameter int WEIGHT_FRAC_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    fec_item_if.sink               i_item,
    fec_result_if.source           o_result
);

    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic     in_ready;

    assign i_item.ready = in_ready;

    fec_ctrl #(
        .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    fec_datapath #(
        .TIME_BITS        (TIME_BITS),
        .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_op            (i_item.op),
        .i_elapsed_ticks (i_item.elapsed_ticks),
        .i_hold_override (i_item.hold_override),
        .i_immediate     (i_item.immediate),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_out_ready     (o_result.ready),
        .o_out_valid     (o_result.valid),
        .o_phase         (o_result.phase),
        .o_blend_weight  (o_result.blend_weight),
        .o_time_left     (o_result.time_left),
        .o_has_output    (o_result.has_output)
    );

endmodule

`default_nettype wire

// ===== tb/sv/fec_envelope_checker.sv =====
`timescale 1ns / 1ps

module fec_envelope_checker import fec_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    fec_item_if                   i_item,
    fec_result_if                 i_result,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_checked
);

    localparam int          FRAC_BITS = 16;
    localparam logic [63:0] UNITY     = 64'd1 << FRAC_BITS;
    localparam logic [63:0] TICKS_SAT = (64'd1 << TICK_W) - 64'd1;
    localparam logic [63:0] LEFT_SAT  = (64'd1 << LEFT_W) - 64'd1;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [BLEND_W-1:0] blend_weight;
        logic [LEFT_W-1:0]  time_left;
        logic               has_output;
    } t_envelope_view;

    logic [CFG_DATA_W-1:0] fade_in_len;
    logic [CFG_DATA_W-1:0] fade_out_len;
    logic [CFG_DATA_W-1:0] hold_default;
    t_phase                env_phase;
    t_phase                resume_phase;
    logic [TICK_W-1:0]     phase_ticks;
    logic [TICK_W-1:0]     hold_len;
    logic [BLEND_W-1:0]    weight;
    t_envelope_view        expected_q[$];

    // re-entering the current phase keeps its time
    function automatic void move_to(input t_phase next);
        if (env_phase != next) begin
            env_phase   = next;
            phase_ticks = '0;
        end
    endfunction

    function automatic logic [63:0] smoothstep(input logic [63:0] frac);
        logic [63:0] sq;
        if (frac > UNITY)
            frac = UNITY;
        sq = (frac * frac) >> FRAC_BITS;
        return (sq * (3 * UNITY - 2 * frac)) >> FRAC_BITS;
    endfunction

    function automatic logic [63:0] floor_sub(input logic [63:0] a, input logic [63:0] b);
        return (a > b) ? a - b : 64'd0;
    endfunction

    function automatic logic [63:0] phase_weight();
        logic [63:0] t;
        logic [63:0] f_in;
        logic [63:0] f_out;
        t     = 64'(phase_ticks);
        f_in  = 64'(fade_in_len);
        f_out = 64'(fade_out_len);
        case (env_phase)
            PH_FADE_IN: begin
                if (f_in == 0 || t >= f_in)
                    return UNITY;
                return smoothstep((t * UNITY) / f_in);
            end
            PH_HOLD:
                return UNITY;
            PH_FADE_OUT: begin
                if (f_out == 0 || t >= f_out)
                    return 64'd0;
                return smoothstep(((f_out - t) * UNITY) / f_out);
            end
            PH_PAUSED:
                return 64'(weight);
            default:
                return 64'd0;
        endcase
    endfunction

    function automatic logic [LEFT_W-1:0] ticks_remaining();
        logic [63:0] r;
        case (env_phase)
            PH_FADE_IN:
                r = floor_sub(fade_in_len, phase_ticks) + hold_len + fade_out_len;
            // endless hold only counts the fade-out
            PH_HOLD:
                r = ((hold_len != 0) ? floor_sub(hold_len, phase_ticks) : 64'd0) + fade_out_len;
            PH_FADE_OUT:
                r = floor_sub(fade_out_len, phase_ticks);
            default:
                r = 64'd0;
        endcase
        return (r > LEFT_SAT) ? LEFT_SAT[LEFT_W-1:0] : r[LEFT_W-1:0];
    endfunction

    function automatic void apply_tick(input logic [TICK_W-1:0] dt);
        logic [63:0] sum;
        if (env_phase == PH_INACTIVE || env_phase == PH_PAUSED)
            return;
        sum         = 64'(phase_ticks) + 64'(dt);
        phase_ticks = (sum > TICKS_SAT) ? TICKS_SAT[TICK_W-1:0] : sum[TICK_W-1:0];
        case (env_phase)
            PH_FADE_IN:
                if (fade_in_len == 0 || phase_ticks >= fade_in_len)
                    move_to(PH_HOLD);
            PH_HOLD:
                if (hold_len != 0 && phase_ticks >= hold_len)
                    move_to(PH_FADE_OUT);
            PH_FADE_OUT:
                if (fade_out_len == 0 || phase_ticks >= fade_out_len)
                    move_to(PH_INACTIVE);
            default: ;
        endcase
        weight = BLEND_W'(phase_weight());
    endfunction

    function automatic t_envelope_view step_envelope(
        input logic [OP_W-1:0]   op,
        input logic [TICK_W-1:0] dt,
        input logic [TICK_W-1:0] hold,
        input logic              imm
    );
        t_envelope_view v;
        case (op)
            OP_TICK:
                apply_tick(dt);
            OP_TRIGGER: begin
                hold_len = (hold != 0) ? hold : hold_default;
                move_to(PH_FADE_IN);
            end
            OP_STOP:
                if (env_phase != PH_INACTIVE) begin
                    if (imm)
                        move_to(PH_INACTIVE);
                    else if (env_phase != PH_FADE_OUT)
                        move_to(PH_FADE_OUT);
                end
            OP_PAUSE:
                if (env_phase != PH_INACTIVE && env_phase != PH_PAUSED) begin
                    resume_phase = env_phase;
                    env_phase    = PH_PAUSED;
                end
            OP_RESUME:
                if (env_phase == PH_PAUSED)
                    env_phase = resume_phase;
            default: ;
        endcase
        v.phase        = env_phase;
        v.blend_weight = weight;
        v.time_left    = ticks_remaining();
        v.has_output   = (env_phase != PH_INACTIVE)
                         && (64'(weight) * 64'(HAS_OUT_SCALE) > UNITY);
        return v;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : track
        t_envelope_view want;
        if (!i_rst_n) begin
            fade_in_len  = '0;
            fade_out_len = '0;
            hold_default = '0;
            env_phase    = PH_INACTIVE;
            resume_phase = PH_INACTIVE;
            phase_ticks  = '0;
            hold_len     = '0;
            weight       = '0;
            expected_q.delete();
            o_pending    = 0;
            o_checked    = 0;
            o_fail_count = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FADE_IN:     fade_in_len  = i_cfg_data;
                    CFG_FADE_OUT:    fade_out_len = i_cfg_data;
                    CFG_DEFAULT_HLD: hold_default = i_cfg_data;
                    default: ;
                endcase
            end
            // result side first: a word taken this edge cannot have its result yet
            if (i_result.valid && i_result.ready) begin
                if (expected_q.size() == 0) begin
                    $error("unexpected result word: phase %0d, weight %0d, time_left %0d",
                           i_result.phase, i_result.blend_weight, i_result.time_left);
                    o_fail_count++;
                end else begin
                    want = expected_q.pop_front();
                    o_pending--;
                    o_checked++;
                    check_field("phase", want.phase, i_result.phase);
                    check_field("blend_weight", want.blend_weight, i_result.blend_weight);
                    check_field("time_left", want.time_left, i_result.time_left);
                    check_field("has_output", want.has_output, i_result.has_output);
                end
            end
            if (i_item.valid && i_item.ready) begin
                expected_q.push_back(step_envelope(i_item.op, i_item.elapsed_ticks,
                                                   i_item.hold_override, i_item.immediate));
                o_pending++;
            end
        end
    end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import fec_pkg::*;

    localparam int              HOLD_OFF_CYCLES = 300;
    localparam int              WATCHDOG_LIMIT  = 3000;
    localparam int              DRAIN_CYCLES    = 32;
    localparam int              PHASE_COUNT     = 8;
    localparam int              WORDS_PER_PHASE = 68;
    localparam logic [OP_W-1:0] OP_UNUSED_TOP   = {OP_W{1'b1}};

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx      = CFG_FADE_IN;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;
    t_idle_mode            idle_mode    = IDLE_NONE;
    logic                  hold_off_req = 1'b0;
    int                    words_sent   = 0;
    int                    cfg_sets     = 0;
    int                    fail_count;
    int                    pending;
    int                    checked;

    fec_item_if   item_ch();
    fec_result_if result_ch();

    fade_envelope_controller_core DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_item     (item_ch),
        .o_result   (result_ch)
    );

    fec_envelope_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_item       (item_ch),
        .i_result     (result_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int gap_pct(input t_idle_mode m);
        return (m == IDLE_SENDER) ? 79 : (m == IDLE_BOTH) ? 10 : 0;
    endfunction

    function automatic int stall_pct(input t_idle_mode m);
        return (m == IDLE_RECEIVER) ? 79 : (m == IDLE_BOTH) ? 10 : 0;
    endfunction

    function automatic logic [TICK_W-1:0] rand_dt();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return TICK_W'($urandom_range(0, 6));
        if (r < 88)
            return TICK_W'($urandom_range(0, 48));
        return TICK_W'($urandom);
    endfunction

    function automatic logic [TICK_W-1:0] rand_hold();
        int r;
        r = $urandom_range(99);
        if (r < 40)
            return '0;
        if (r < 85)
            return TICK_W'($urandom_range(1, 20));
        return TICK_W'($urandom);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_len();
        if ($urandom_range(99) < 70)
            return CFG_DATA_W'($urandom_range(0, 24));
        return CFG_DATA_W'($urandom);
    endfunction

    // starts and ends on a falling edge; valid is left high for the caller
    task automatic push_word(input logic [OP_W-1:0] op, input logic [TICK_W-1:0] dt,
                             input logic [TICK_W-1:0] hold, input logic imm);
        while ($urandom_range(99) < gap_pct(idle_mode)) begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.valid         <= 1'b1;
        item_ch.op            <= op;
        item_ch.elapsed_ticks <= dt;
        item_ch.hold_override <= hold;
        item_ch.immediate     <= imm;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        words_sent++;
        @(negedge clk);
    endtask

    task automatic push_op(input logic [OP_W-1:0] op);
        push_word(op, rand_dt(), rand_hold(), 1'($urandom_range(1)));
    endtask

    task automatic write_regs(input logic [CFG_DATA_W-1:0] f_in,
                              input logic [CFG_DATA_W-1:0] f_out,
                              input logic [CFG_DATA_W-1:0] hold);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_FADE_IN;
        cfg_data <= f_in;
        @(negedge clk);
        cfg_idx  <= CFG_FADE_OUT;
        cfg_data <= f_out;
        @(negedge clk);
        cfg_idx  <= CFG_DEFAULT_HLD;
        cfg_data <= hold;
        @(negedge clk);
        cfg_we   <= 1'b0;
        cfg_sets++;
    endtask

    task automatic settle();
        item_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // trigger, a run of mostly ticks with some pause/resume/retrigger/stop, then a stop and trailing ticks
    task automatic run_envelope();
        int steps;
        int r;
        push_op(OP_TRIGGER);
        steps = $urandom_range(2, 14);
        repeat (steps) begin
            r = $urandom_range(99);
            if (r < 62)
                push_op(OP_TICK);
            else if (r < 72)
                push_op(OP_PAUSE);
            else if (r < 82)
                push_op(OP_RESUME);
            else if (r < 90)
                push_op(OP_TRIGGER);
            else
                push_word(OP_STOP, rand_dt(), rand_hold(), $urandom_range(3) == 0);
        end
        push_word(OP_STOP, rand_dt(), rand_hold(), $urandom_range(3) == 0);
        repeat ($urandom_range(1, 4))
            push_op(OP_TICK);
    endtask

    initial begin : result_sink
        result_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                result_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES)
                    @(negedge clk);
            end
            result_ch.ready <= ($urandom_range(99) >= stall_pct(idle_mode));
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin : stimulus
        int budget;
        item_ch.valid         = 1'b0;
        item_ch.op            = OP_TICK;
        item_ch.elapsed_ticks = '0;
        item_ch.hold_override = '0;
        item_ch.immediate     = 1'b0;
        repeat (8)
            @(negedge clk);
        rst_n <= 1'b1;

        write_regs(16'd4, 16'd4, 16'd3);
        // ignored while inactive
        push_word(OP_TICK, '1, '0, 1'b0);
        push_word(OP_STOP, '0, '0, 1'b0);
        push_word(OP_STOP, '0, '0, 1'b1);
        push_word(OP_PAUSE, '0, '0, 1'b0);
        push_word(OP_RESUME, '0, '0, 1'b0);
        push_word(OP_UNUSED_TOP, '1, '1, 1'b1);
        push_word(OP_TRIGGER, '0, '0, 1'b0);
        push_word(OP_TICK, 16'd1, '0, 1'b0);
        // retrigger while fading in keeps time, takes new hold
        push_word(OP_TRIGGER, '0, '1, 1'b0);
        push_word(OP_PAUSE, '0, '0, 1'b0);
        push_word(OP_TICK, 16'd2, '0, 1'b0);
        push_word(OP_RESUME, '0, '0, 1'b0);
        push_word(OP_PAUSE, '0, '0, 1'b0);
        push_word(OP_TRIGGER, '0, 16'd3, 1'b0);
        push_word(OP_TICK, 16'd4, '0, 1'b0);
        push_word(OP_STOP, '0, '0, 1'b0);
        push_word(OP_STOP, '0, '0, 1'b0);
        push_word(OP_TICK, 16'd1, '0, 1'b0);
        push_word(OP_PAUSE, '0, '0, 1'b0);
        push_word(OP_STOP, '0, '0, 1'b0);
        push_word(OP_TICK, '1, '0, 1'b0);
        push_word(OP_TRIGGER, '0, 16'h8000, 1'b0);
        push_word(OP_STOP, '0, '0, 1'b1);

        // instant fades, endless hold, saturating phase time
        settle();
        write_regs('0, '0, '0);
        push_word(OP_TRIGGER, '0, '0, 1'b0);
        push_word(OP_TICK, '0, '0, 1'b0);
        push_word(OP_TICK, '1, '0, 1'b0);
        push_word(OP_TICK, '1, '0, 1'b0);
        push_word(OP_STOP, '0, '0, 1'b0);
        push_word(OP_TICK, '0, '0, 1'b0);

        for (int p = 0; p < PHASE_COUNT; p++) begin
            settle();
            idle_mode = t_idle_mode'(p % 4);
            case (p)
                1:       write_regs('1, '1, '1);
                2:       write_regs('0, '0, '0);
                default: write_regs(rand_len(), rand_len(), rand_len());
            endcase
            // long result hold-off with the sender still pushing
            if (p == 0)
                hold_off_req = 1'b1;
            budget = words_sent + WORDS_PER_PHASE;
            while (words_sent < budget) begin
                if ($urandom_range(99) < 80)
                    run_envelope();
                else
                    push_word(OP_W'($urandom_range(0, 2 ** OP_W - 1)), TICK_W'($urandom),
                              TICK_W'($urandom), 1'($urandom_range(1)));
            end
        end

        settle();
        repeat (DRAIN_CYCLES)
            @(negedge clk);
        $display("Drove %0d words across %0d register settings and four idle patterns;",
                 words_sent, cfg_sets);
        $display("compared %0d result words against the envelope predictor.", checked);
        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
